// ===== hw/rtl/lsbx_pkg.sv =====
// Shared types, register codes and result codes for the LSB payload extractor.
// No dependencies; every other file in hw/rtl imports this package.
package lsbx_pkg;

    localparam int MAGIC_IDX_W = 4;

    typedef enum logic [1:0] {
        REG_HEADER_SKIP  = 2'd0,
        REG_MAGIC_LENGTH = 2'd1,
        REG_MAGIC_LOW    = 2'd2,
        REG_MAGIC_HIGH   = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        PH_SKIP  = 3'd0,
        PH_MLEN  = 3'd1,
        PH_MAGIC = 3'd2,
        PH_ELEN  = 3'd3,
        PH_EXT   = 3'd4,
        PH_PLEN  = 3'd5,
        PH_DATA  = 3'd6,
        PH_IDLE  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_EXT_BYTE,
        EV_DATA_BYTE,
        EV_DATA_LAST,
        EV_EMPTY_PAYLOAD,
        EV_MISMATCH,
        EV_MAGIC_LONG,
        EV_EXT_LONG
    } event_t;

    localparam logic [1:0] KIND_EXTENSION = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
    localparam logic [1:0] KIND_STATUS    = 2'd2;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH   = 2'd1;
    localparam logic [1:0] STATUS_MAGIC_LONG = 2'd2;
    localparam logic [1:0] STATUS_EXT_LONG   = 2'd3;

    localparam logic [15:0] HEADER_SKIP_RESET = 16'd54;

    typedef struct packed {
        logic [15:0] header_skip;
        logic [3:0]  magic_length;
        logic [63:0] magic_low;
        logic [15:0] magic_high;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic [1:0] status;
        logic       last;
    } result_t;

    function automatic logic [7:0] expected_byte(input cfg_t cfg,
                                                 input logic [MAGIC_IDX_W-1:0] idx);
        logic [7:0] b;
        if (idx < 4'd8) begin
            b = cfg.magic_low[{idx[2:0], 3'b000} +: 8];
        end else if (idx < 4'd10) begin
            b = cfg.magic_high[{idx[0], 3'b000} +: 8];
        end else begin
            b = 8'd0;
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/lsbx_cfg_regs.sv =====
// Configuration register file of the LSB payload extractor.
// Depends on lsbx_pkg for cfg_t and the register index codes.
module lsbx_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_wr_addr,
    input  logic [63:0]   cfg_wr_data,
    output lsbx_pkg::cfg_t cfg
);
    import lsbx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_wr_addr))
                REG_HEADER_SKIP:  cfg_next.header_skip  = cfg_wr_data[15:0];
                REG_MAGIC_LENGTH: cfg_next.magic_length = cfg_wr_data[3:0];
                REG_MAGIC_LOW:    cfg_next.magic_low    = cfg_wr_data;
                REG_MAGIC_HIGH:   cfg_next.magic_high   = cfg_wr_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_skip  <= HEADER_SKIP_RESET;
            cfg_reg.magic_length <= '0;
            cfg_reg.magic_low    <= '0;
            cfg_reg.magic_high   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/lsbx_parser.sv =====
// Parse state machine: header skip, length and byte collection, magic check.
// Depends on lsbx_pkg for the phase and event codes and the result struct.
module lsbx_parser #(
    parameter int MAX_MAGIC     = 10,
    parameter int MAX_EXTENSION = 9,
    parameter int LENGTH_BITS   = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lsbx_pkg::cfg_t   cfg,
    input  logic             accept,
    input  logic [7:0]       pixel_byte,
    input  logic             restart,
    output logic             res_valid,
    output lsbx_pkg::result_t res
);
    import lsbx_pkg::*;

    localparam int LEN_W = LENGTH_BITS;
    localparam int BIT_W = $clog2(LENGTH_BITS);

    phase_t                 phase_reg, phase_next;
    logic [15:0]            skip_reg, skip_next;
    logic [BIT_W-1:0]       bit_idx_reg, bit_idx_next;
    logic [LEN_W-1:0]       len_acc_reg, len_acc_next;
    logic [7:0]             byte_acc_reg, byte_acc_next;
    logic [LEN_W-1:0]       remain_reg, remain_next;
    logic [MAGIC_IDX_W-1:0] magic_idx_reg, magic_idx_next;
    logic                   match_reg, match_next;
    event_t                 ev;
    logic [7:0]             ev_byte;

    always_comb begin
        logic             go;
        logic             bit_in;
        logic [LEN_W-1:0] len_bit;
        logic             len_done;
        logic [7:0]       byte_val;
        logic             byte_done;

        phase_next     = phase_reg;
        skip_next      = skip_reg;
        bit_idx_next   = bit_idx_reg;
        len_acc_next   = len_acc_reg;
        byte_acc_next  = byte_acc_reg;
        remain_next    = remain_reg;
        magic_idx_next = magic_idx_reg;
        match_next     = match_reg;
        ev             = EV_NONE;
        ev_byte        = 8'd0;
        go             = 1'b1;
        bit_in         = pixel_byte[0];

        if (restart) begin
            phase_next     = PH_SKIP;
            skip_next      = '0;
            bit_idx_next   = '0;
            len_acc_next   = '0;
            byte_acc_next  = '0;
            remain_next    = '0;
            magic_idx_next = '0;
            match_next     = 1'b1;
        end

        if (phase_next == PH_SKIP) begin
            if (skip_next < cfg.header_skip) begin
                skip_next = skip_next + 16'd1;
                go = 1'b0;
            end else begin
                phase_next   = PH_MLEN;
                bit_idx_next = '0;
                len_acc_next = '0;
            end
        end

        len_bit   = len_acc_next | (LEN_W'(bit_in) << bit_idx_next);
        len_done  = (bit_idx_next == BIT_W'(LENGTH_BITS - 1));
        byte_val  = byte_acc_next | (8'(bit_in) << bit_idx_next[2:0]);
        byte_done = (bit_idx_next >= BIT_W'(7));

        if (go) begin
            unique case (phase_next)
                PH_MLEN: begin
                    len_acc_next = len_bit;
                    if (!len_done) begin
                        bit_idx_next = bit_idx_next + BIT_W'(1);
                    end else begin
                        bit_idx_next = '0;
                        if (len_bit > LEN_W'(MAX_MAGIC)) begin
                            phase_next = PH_IDLE;
                            ev = EV_MAGIC_LONG;
                        end else begin
                            remain_next    = len_bit;
                            magic_idx_next = '0;
                            match_next     = 1'b1;
                            byte_acc_next  = '0;
                            if (len_bit == '0) begin
                                if (LEN_W'(cfg.magic_length) == len_bit) begin
                                    phase_next   = PH_ELEN;
                                    len_acc_next = '0;
                                end else begin
                                    phase_next = PH_IDLE;
                                    ev = EV_MISMATCH;
                                end
                            end else begin
                                phase_next = PH_MAGIC;
                            end
                        end
                    end
                end
                PH_MAGIC: begin
                    byte_acc_next = byte_val;
                    if (!byte_done) begin
                        bit_idx_next = bit_idx_next + BIT_W'(1);
                    end else begin
                        bit_idx_next = '0;
                        if (byte_val != expected_byte(cfg, magic_idx_next)) begin
                            match_next = 1'b0;
                        end
                        magic_idx_next = magic_idx_next + MAGIC_IDX_W'(1);
                        byte_acc_next  = '0;
                        remain_next    = remain_next - LEN_W'(1);
                        if (remain_next == '0) begin
                            if (match_next && LEN_W'(cfg.magic_length) == len_acc_next) begin
                                phase_next   = PH_ELEN;
                                len_acc_next = '0;
                            end else begin
                                phase_next = PH_IDLE;
                                ev = EV_MISMATCH;
                            end
                        end
                    end
                end
                PH_ELEN: begin
                    len_acc_next = len_bit;
                    if (!len_done) begin
                        bit_idx_next = bit_idx_next + BIT_W'(1);
                    end else begin
                        bit_idx_next = '0;
                        if (len_bit > LEN_W'(MAX_EXTENSION)) begin
                            phase_next = PH_IDLE;
                            ev = EV_EXT_LONG;
                        end else begin
                            remain_next   = len_bit;
                            byte_acc_next = '0;
                            if (len_bit == '0) begin
                                phase_next   = PH_PLEN;
                                len_acc_next = '0;
                            end else begin
                                phase_next = PH_EXT;
                            end
                        end
                    end
                end
                PH_EXT: begin
                    byte_acc_next = byte_val;
                    if (!byte_done) begin
                        bit_idx_next = bit_idx_next + BIT_W'(1);
                    end else begin
                        bit_idx_next  = '0;
                        ev            = EV_EXT_BYTE;
                        ev_byte       = byte_val;
                        byte_acc_next = '0;
                        remain_next   = remain_next - LEN_W'(1);
                        if (remain_next == '0) begin
                            phase_next   = PH_PLEN;
                            len_acc_next = '0;
                        end
                    end
                end
                PH_PLEN: begin
                    len_acc_next = len_bit;
                    if (!len_done) begin
                        bit_idx_next = bit_idx_next + BIT_W'(1);
                    end else begin
                        bit_idx_next  = '0;
                        remain_next   = len_bit;
                        byte_acc_next = '0;
                        if (len_bit == '0) begin
                            phase_next = PH_IDLE;
                            ev = EV_EMPTY_PAYLOAD;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    byte_acc_next = byte_val;
                    if (!byte_done) begin
                        bit_idx_next = bit_idx_next + BIT_W'(1);
                    end else begin
                        bit_idx_next  = '0;
                        ev_byte       = byte_val;
                        byte_acc_next = '0;
                        remain_next   = remain_next - LEN_W'(1);
                        if (remain_next == '0) begin
                            phase_next = PH_IDLE;
                            ev = EV_DATA_LAST;
                        end else begin
                            ev = EV_DATA_BYTE;
                        end
                    end
                end
                PH_SKIP, PH_IDLE: begin
                    phase_next = phase_next;
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        res_valid = 1'b1;
        res       = '{out_byte: 8'd0, kind: KIND_STATUS, status: STATUS_OK, last: 1'b1};
        unique case (ev)
            EV_NONE:          res_valid = 1'b0;
            EV_EXT_BYTE:      res = '{ev_byte, KIND_EXTENSION, STATUS_OK, 1'b0};
            EV_DATA_BYTE:     res = '{ev_byte, KIND_PAYLOAD, STATUS_OK, 1'b0};
            EV_DATA_LAST:     res = '{ev_byte, KIND_PAYLOAD, STATUS_OK, 1'b1};
            EV_EMPTY_PAYLOAD: res.status = STATUS_OK;
            EV_MISMATCH:      res.status = STATUS_MISMATCH;
            EV_MAGIC_LONG:    res.status = STATUS_MAGIC_LONG;
            EV_EXT_LONG:      res.status = STATUS_EXT_LONG;
            default:          res_valid = 1'b0;
        endcase
        res_valid = res_valid & accept;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SKIP;
            skip_reg      <= '0;
            bit_idx_reg   <= '0;
            len_acc_reg   <= '0;
            byte_acc_reg  <= '0;
            remain_reg    <= '0;
            magic_idx_reg <= '0;
            match_reg     <= 1'b1;
        end else if (accept) begin
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            bit_idx_reg   <= bit_idx_next;
            len_acc_reg   <= len_acc_next;
            byte_acc_reg  <= byte_acc_next;
            remain_reg    <= remain_next;
            magic_idx_reg <= magic_idx_next;
            match_reg     <= match_next;
        end
    end

endmodule

// ===== hw/rtl/lsbx_out_queue.sv =====
// Two-entry result buffer that decouples the parser from output stalls.
// Depends on lsbx_pkg for result_t.
module lsbx_out_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lsbx_pkg::result_t push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output lsbx_pkg::result_t head
);
    import lsbx_pkg::*;

    result_t    ent0_reg, ent0_next;
    result_t    ent1_reg, ent1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign m_valid = (count_reg != 2'd0);
    assign space   = (count_reg != 2'd2);
    assign head    = ent0_reg;
    assign pop     = m_valid && m_ready;

    always_comb begin
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                ent0_next = push_data;
            end else begin
                ent1_next = push_data;
            end
        end else if (pop && !push) begin
            ent0_next = ent1_reg;
        end else if (pop && push) begin
            if (count_reg == 2'd1) begin
                ent0_next = push_data;
            end else begin
                ent0_next = ent1_reg;
                ent1_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

endmodule

// ===== hw/rtl/lsb_stego_payload_extractor_unit.sv =====
// Top level of the LSB payload extractor: config registers, parser, result buffer.
// Depends on lsbx_pkg, lsbx_cfg_regs, lsbx_parser and lsbx_out_queue.
//
// One image byte is taken per request every clock cycle while s_ready is high;
// each byte updates the parse state, and any result it causes is registered into
// the two-entry result buffer, whose head drives the m_ side. That buffer keeps
// s_ready high while one result waits, so the input stalls only when two wait.
module lsb_stego_payload_extractor_unit #(
    parameter int MAX_MAGIC     = 10,
    parameter int MAX_EXTENSION = 9,
    parameter int LENGTH_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_addr,
    input  logic [63:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_pixel_byte,
    input  logic        s_restart,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic [1:0]  m_kind,
    output logic [1:0]  m_status,
    output logic        m_last
);
    import lsbx_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t head;
    logic    res_valid;
    logic    accept;

    assign accept = s_valid && s_ready;

    lsbx_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    lsbx_parser #(
        .MAX_MAGIC     (MAX_MAGIC),
        .MAX_EXTENSION (MAX_EXTENSION),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .pixel_byte (s_pixel_byte),
        .restart    (s_restart),
        .res_valid  (res_valid),
        .res        (res)
    );

    lsbx_out_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    assign m_out_byte = head.out_byte;
    assign m_kind     = head.kind;
    assign m_status   = head.status;
    assign m_last     = head.last;

endmodule

// ===== hw/rtl/lsbx_checker.sv =====
// Port-level checks for the LSB payload extractor, bound to the top level.
// Depends on lsbx_pkg for the kind and status codes.
module lsbx_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_byte,
    input logic [1:0] m_kind,
    input logic [1:0] m_status,
    input logic       m_last
);
    import lsbx_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_kind)
                                && $stable(m_status) && $stable(m_last))
        else $error("stalled result changed");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_STATUS |-> m_last && m_out_byte == 8'd0)
        else $error("status result without last or with data");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_STATUS |-> m_status == STATUS_OK)
        else $error("byte result carries error status");

    a_kind_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_kind != KIND_UNUSED && !(m_kind == KIND_EXTENSION && m_last))
        else $error("bad kind or last on extension byte");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind lsb_stego_payload_extractor_unit lsbx_checker u_chk (.*);

// ===== verif/lsb_stego_payload_extractor_unit_tb.sv =====
// Self-checking testbench for lsb_stego_payload_extractor_unit: hidden-field images,
// error and truncated streams, random request/result stalls. Depends on lsbx_pkg and the RTL.
`timescale 1ns / 100ps

module lsb_stego_payload_extractor_unit_tb;
    import lsbx_pkg::*;

    localparam int MAGIC_MAX    = 10;
    localparam int EXT_MAX      = 9;
    localparam int LEN_BITS     = 32;
    localparam int PAY_CAP      = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_ITEMS   = 700;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_addr;
    logic [63:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_pixel_byte;
    logic        s_restart;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_out_byte;
    logic [1:0]  m_kind;
    logic [1:0]  m_status;
    logic        m_last;

    // decoder shadow state
    cfg_t        cfg_m;
    phase_t      ph;
    logic [15:0] skip_cnt;
    logic [4:0]  bit_idx;
    logic [31:0] len_acc;
    logic [7:0]  byte_acc;
    logic [31:0] remain;
    logic [3:0]  mag_idx;
    logic        mag_ok;

    result_t expected_recovered[$];
    logic    hidden_bits[$];

    int  err_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  status_seen = 0;
    int  config_count = 0;
    int  cycle_count = 0;
    bit  idle_on = 1'b1;
    bit  hold_sink = 1'b0;

    lsb_stego_payload_extractor_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_addr  (cfg_wr_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_pixel_byte (s_pixel_byte),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_kind       (m_kind),
        .m_status     (m_status),
        .m_last       (m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_recovered.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_parse();
        ph       = PH_SKIP;
        skip_cnt = '0;
        bit_idx  = '0;
        len_acc  = '0;
        byte_acc = '0;
        remain   = '0;
        mag_idx  = '0;
        mag_ok   = 1'b1;
    endfunction

    function automatic logic [7:0] magic_byte(input int idx);
        logic [79:0] all;
        all = {cfg_m.magic_high, cfg_m.magic_low};
        return (idx < 10) ? all[idx*8 +: 8] : 8'd0;
    endfunction

    function automatic void open_length(input phase_t nxt);
        ph      = nxt;
        bit_idx = '0;
        len_acc = '0;
    endfunction

    function automatic bit length_bit(input logic b);
        len_acc = len_acc | (32'(b) << bit_idx);
        if (int'(bit_idx) + 1 >= LEN_BITS) begin
            bit_idx = '0;
            return 1'b1;
        end
        bit_idx = bit_idx + 5'd1;
        return 1'b0;
    endfunction

    function automatic bit byte_bit(input logic b);
        byte_acc = byte_acc | (8'(b) << bit_idx);
        if (bit_idx >= 5'd7) begin
            bit_idx = '0;
            return 1'b1;
        end
        bit_idx = bit_idx + 5'd1;
        return 1'b0;
    endfunction

    function automatic result_t end_status(input logic [1:0] st);
        ph = PH_IDLE;
        return '{8'd0, KIND_STATUS, st, 1'b1};
    endfunction

    function automatic bit magic_verdict(output result_t r);
        r = '0;
        if (mag_ok && 32'(cfg_m.magic_length) == len_acc) begin
            open_length(PH_ELEN);
            return 1'b0;
        end
        r = end_status(STATUS_MISMATCH);
        return 1'b1;
    endfunction

    // Advance the decoder by one image byte; return 1 when it yields a result.
    function automatic bit extract_step(input logic [7:0] pb, input logic rs,
                                        output result_t r);
        logic b;
        b = pb[0];
        r = '0;
        if (rs) clear_parse();
        if (ph == PH_SKIP) begin
            if (skip_cnt < cfg_m.header_skip) begin
                skip_cnt = skip_cnt + 16'd1;
                return 1'b0;
            end
            open_length(PH_MLEN);
        end
        case (ph)
            PH_MLEN: begin
                if (!length_bit(b)) return 1'b0;
                if (len_acc > MAGIC_MAX) begin
                    r = end_status(STATUS_MAGIC_LONG);
                    return 1'b1;
                end
                remain   = len_acc;
                mag_idx  = '0;
                mag_ok   = 1'b1;
                byte_acc = '0;
                if (remain == 0) return magic_verdict(r);
                ph = PH_MAGIC;
                return 1'b0;
            end
            PH_MAGIC: begin
                if (!byte_bit(b)) return 1'b0;
                if (byte_acc != magic_byte(int'(mag_idx))) mag_ok = 1'b0;
                mag_idx  = mag_idx + 4'd1;
                byte_acc = '0;
                remain   = remain - 32'd1;
                if (remain == 0) return magic_verdict(r);
                return 1'b0;
            end
            PH_ELEN: begin
                if (!length_bit(b)) return 1'b0;
                if (len_acc > EXT_MAX) begin
                    r = end_status(STATUS_EXT_LONG);
                    return 1'b1;
                end
                remain   = len_acc;
                byte_acc = '0;
                if (remain == 0) open_length(PH_PLEN);
                else ph = PH_EXT;
                return 1'b0;
            end
            PH_EXT: begin
                if (!byte_bit(b)) return 1'b0;
                r        = '{byte_acc, KIND_EXTENSION, STATUS_OK, 1'b0};
                byte_acc = '0;
                remain   = remain - 32'd1;
                if (remain == 0) open_length(PH_PLEN);
                return 1'b1;
            end
            PH_PLEN: begin
                if (!length_bit(b)) return 1'b0;
                remain   = len_acc;
                byte_acc = '0;
                if (remain == 0) begin
                    r = end_status(STATUS_OK);
                    return 1'b1;
                end
                ph = PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                if (!byte_bit(b)) return 1'b0;
                remain   = remain - 32'd1;
                r        = '{byte_acc, KIND_PAYLOAD, STATUS_OK, remain == 0};
                byte_acc = '0;
                if (remain == 0) ph = PH_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name,
                     want, got);
            err_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_kind == KIND_STATUS) status_seen++;
            if (expected_recovered.size() == 0) begin
                $display("%0t: unexpected result, expected none actual byte 0x%0h",
                         $time, m_out_byte);
                $display("    kind %0d status %0d last %0b", m_kind, m_status, m_last);
                err_count++;
            end else begin
                want = expected_recovered.pop_front();
                check_field("out_byte", want.out_byte, m_out_byte);
                check_field("kind", 8'(want.kind), 8'(m_kind));
                check_field("status", 8'(want.status), 8'(m_status));
                check_field("last", 8'(want.last), 8'(m_last));
            end
        end
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin : sink_ctrl
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_sink) begin
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge aclk);
                hold_sink = 1'b0;
                m_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic [7:0] pb, input logic rs);
        result_t r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_pixel_byte <= pb;
        s_restart    <= rs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (extract_step(pb, rs, r)) expected_recovered.push_back(r);
    endtask

    // Drop valid, wait for every expected result, then let the pipeline empty.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_recovered.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_reg(input reg_index_t idx, input logic [63:0] d);
        cfg_wr_en   <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= d;
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [63:0] d_skip, input logic [63:0] d_mlen,
                                input logic [63:0] d_lo, input logic [63:0] d_hi);
        put_reg(REG_HEADER_SKIP, d_skip);
        put_reg(REG_MAGIC_LENGTH, d_mlen);
        put_reg(REG_MAGIC_LOW, d_lo);
        put_reg(REG_MAGIC_HIGH, d_hi);
        cfg_wr_en <= 1'b0;
        cfg_m.header_skip  = d_skip[15:0];
        cfg_m.magic_length = d_mlen[3:0];
        cfg_m.magic_low    = d_lo;
        cfg_m.magic_high   = d_hi[15:0];
        config_count++;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_length(input logic [31:0] v);
        for (int i = 0; i < LEN_BITS; i++) hidden_bits.push_back(v[i]);
    endtask

    task automatic add_byte(input logic [7:0] v);
        for (int i = 0; i < 8; i++) hidden_bits.push_back(v[i]);
    endtask

    task automatic compose_image(input logic [31:0] mlen, input int flip_at,
                                 input logic [31:0] elen, input logic [31:0] plen,
                                 input int tail);
        add_length(mlen);
        if (mlen <= MAGIC_MAX) begin
            for (int i = 0; i < int'(mlen); i++)
                add_byte(magic_byte(i) ^ ((i == flip_at) ? 8'h01 << $urandom_range(0, 7)
                                                         : 8'h00));
            add_length(elen);
            if (elen <= EXT_MAX) begin
                for (int i = 0; i < int'(elen); i++) add_byte(pick_byte());
                add_length(plen);
                for (int i = 0; i < PAY_CAP && i < plen; i++) add_byte(pick_byte());
            end
        end
        repeat (tail) hidden_bits.push_back(1'($urandom));
    endtask

    // Header bytes first, then one hidden bit per byte; cut < 0 sends everything.
    task automatic send_image(input int cut);
        int n;
        bit first;
        n = hidden_bits.size();
        if (cut >= 0 && cut < n) n = cut;
        first = 1'b1;
        repeat (cfg_m.header_skip) begin
            send_pixel(8'($urandom), first);
            first = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            send_pixel({7'($urandom), hidden_bits[i]}, first);
            first = 1'b0;
        end
        hidden_bits.delete();
    endtask

    task automatic test_reset_defaults();
        compose_image(0, -1, 0, 0, 10);
        send_image(-1);
        compose_image(0, -1, 2, 1, 4);
        send_image(-1);
        settle();
    endtask

    task automatic test_zero_skip_magic();
        write_config(64'h0, 64'd10, 64'h0041_5AFF_007E_0180, 64'h00C3);
        compose_image(10, -1, 9, 3, 3);
        send_image(-1);
        compose_image(10, -1, 0, 1, 0);
        send_image(-1);
        settle();
    endtask

    task automatic test_magic_errors();
        compose_image(10, 0, 0, 1, 8);
        send_image(-1);
        compose_image(10, 9, 0, 1, 8);
        send_image(-1);
        compose_image(9, -1, 0, 1, 0);
        send_image(-1);
        compose_image(11, -1, 0, 1, 0);
        send_image(-1);
        compose_image(32'hFFFF_FFFF, -1, 0, 1, 0);
        send_image(-1);
        settle();
        write_config(64'hFFFF_0000_0000_0001, 64'hFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF);
        compose_image(10, -1, 0, 1, 0);
        send_image(-1);
        compose_image(15, -1, 0, 1, 0);
        send_image(-1);
        settle();
    endtask

    task automatic test_ext_limits();
        write_config(64'd2, 64'd0, 64'h0, 64'h0);
        compose_image(0, -1, 10, 1, 6);
        send_image(-1);
        compose_image(0, -1, 32'hFFFF_FFFF, 1, 0);
        send_image(-1);
        compose_image(0, -1, 9, 0, 5);
        send_image(-1);
        settle();
    endtask

    task automatic test_restart_midstream();
        compose_image(0, -1, 1, 32'hFFFF_FFFF, 0);
        send_image(3 * LEN_BITS + 8 + 3 * 8);
        compose_image(0, -1, 1, 2, 0);
        send_image(-1);
        settle();
    endtask

    task automatic test_backpressure();
        idle_on = 1'b0;
        write_config(64'd0, 64'd0, 64'h0, 64'h0);
        hold_sink = 1'b1;
        compose_image(0, -1, 4, 40, 0);
        send_image(-1);
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_random();
        int base_items;
        int pick;
        int flip;
        logic [31:0] mlen;
        logic [31:0] elen;
        logic [31:0] plen;
        base_items = items_sent;
        while (items_sent - base_items < RAND_ITEMS) begin
            idle_on = (items_sent - base_items < RAND_ITEMS - 150) &&
                      ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0) begin
                settle();
                write_config({$urandom, 16'($urandom), 16'($urandom_range(0, 6))},
                             {$urandom, 28'($urandom),
                              4'($urandom_range(0, 5) == 0 ? $urandom_range(11, 15)
                                                           : $urandom_range(0, 10))},
                             {$urandom, $urandom}, {$urandom, $urandom});
            end
            mlen = 32'(cfg_m.magic_length);
            flip = -1;
            elen = $urandom_range(0, EXT_MAX);
            plen = $urandom_range(0, 12);
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                compose_image(mlen, flip, elen, plen, $urandom_range(0, 6));
                send_image(-1);
            end else if (pick < 16) begin
                compose_image(mlen, flip, elen, plen, 0);
                send_image($urandom_range(1, hidden_bits.size() - 1));
            end else if (pick < 18) begin
                case ($urandom_range(0, 3))
                    0: mlen = mlen + 32'd1;
                    1: if (mlen != 0) flip = $urandom_range(0, int'(mlen) - 1);
                    2: mlen = $urandom_range(0, 1) ? 32'($urandom_range(11, 20))
                                                   : ($urandom | 32'h8000_0000);
                    default: elen = $urandom_range(0, 1) ? 32'($urandom_range(10, 30))
                                                         : 32'hFFFF_FFFF;
                endcase
                compose_image(mlen, flip, elen, plen, $urandom_range(0, 6));
                send_image(-1);
            end else begin
                repeat ($urandom_range(1, 16))
                    send_pixel(8'($urandom), $urandom_range(0, 5) == 0);
            end
        end
        idle_on = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_addr  = REG_HEADER_SKIP;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_pixel_byte = '0;
        s_restart    = 1'b0;
        cfg_m.header_skip  = HEADER_SKIP_RESET;
        cfg_m.magic_length = '0;
        cfg_m.magic_low    = '0;
        cfg_m.magic_high   = '0;
        clear_parse();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_zero_skip_magic();
        test_magic_errors();
        test_ext_limits();
        test_restart_midstream();
        test_backpressure();
        test_random();
        settle();

        $display("Run covered %0d image bytes, %0d results (%0d status) over %0d register sets",
                 items_sent, results_seen, status_seen, config_count);
        $display("Cases: default and small header skips, magic and extension bounds, truncation");
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
